[rtl/core/tss_pkg.sv]
package tss_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int TILES_W     = 11;
    localparam int PIXEL_W     = 13;
    localparam int WORD_W      = 16;
    localparam int COORD_W     = 12;
    localparam int BASE_W      = 24;
    localparam int RECIP_SHIFT = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_ATTR  = 2'd2;

    localparam logic [TILES_W-1:0] MAP_WIDTH_RESET  = 11'd40;
    localparam logic [TILES_W-1:0] MAP_HEIGHT_RESET = 11'd28;
    localparam logic [WORD_W-1:0]  TILE_ATTR_RESET  = 16'd0;

    localparam logic ITEM_LOAD   = 1'b0;
    localparam logic ITEM_CAMERA = 1'b1;

    localparam logic [1:0] KIND_SCROLL = 2'd0;
    localparam logic [1:0] KIND_COLUMN = 2'd1;
    localparam logic [1:0] KIND_ROW    = 2'd2;

    typedef struct packed {
        logic [TILES_W-1:0] map_width_tiles;
        logic [TILES_W-1:0] map_height_tiles;
        logic [WORD_W-1:0]  tile_base_attr;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_ADDR,
        ST_READ,
        ST_SETTLE,
        ST_EMIT
    } state_t;

endpackage

[rtl/core/tilemap_scroll_streamer.sv]
// Tile map scroll streamer. Map words are loaded one per transfer (kind 0) into a
// MAP_WORDS-deep single-port-read map store. A camera transfer (kind 1) is clamped to
// the map, yields one scroll result, then a 2x2 block result for each block of a new
// column pair (PLANE_ROWS/2 blocks) and/or a new row pair (PLANE_COLS/2 blocks), with
// last set on the final one. The input is not ready while a camera update is in
// progress. Each block has an address multiply, four map store reads through the one
// read port, a wait for read latency and a load of the output register, which waits on
// any output stall. MAP_WORDS must be a power of two; the block does not enforce it.
module tilemap_scroll_streamer #(
    parameter int PLANE_COLS  = 64,
    parameter int PLANE_ROWS  = 32,
    parameter int SCREEN_COLS = 40,
    parameter int SCREEN_ROWS = 28,
    parameter int MAP_WORDS   = 65536
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tss_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic [15:0]                        map_index,
    input  logic [15:0]                        map_word,
    input  logic [12:0]                        camera_x,
    input  logic [12:0]                        camera_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         result_kind,
    output logic [4:0]                         plane_row,
    output logic [5:0]                         plane_col,
    output logic [15:0]                        word_top_left,
    output logic [15:0]                        word_top_right,
    output logic [15:0]                        word_bottom_left,
    output logic [15:0]                        word_bottom_right,
    output logic signed [13:0]                 h_scroll,
    output logic [12:0]                        v_scroll,
    output logic                               last
);

    localparam int ADDR_W = $clog2(MAP_WORDS);

    tss_pkg::cfg_t cfg_reg;

    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [15:0]       mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [15:0]       mem_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width_tiles  <= tss_pkg::MAP_WIDTH_RESET;
            cfg_reg.map_height_tiles <= tss_pkg::MAP_HEIGHT_RESET;
            cfg_reg.tile_base_attr   <= tss_pkg::TILE_ATTR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tss_pkg::REG_MAP_WIDTH:
                begin
                    cfg_reg.map_width_tiles <= cfg_data[tss_pkg::TILES_W-1:0];
                end
                tss_pkg::REG_MAP_HEIGHT:
                begin
                    cfg_reg.map_height_tiles <= cfg_data[tss_pkg::TILES_W-1:0];
                end
                tss_pkg::REG_TILE_ATTR:
                begin
                    cfg_reg.tile_base_attr <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    tss_map_mem #(
        .DEPTH (MAP_WORDS)
    ) u_map_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    tss_ctrl #(
        .PLANE_COLS  (PLANE_COLS),
        .PLANE_ROWS  (PLANE_ROWS),
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .MAP_WORDS   (MAP_WORDS)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .map_index         (map_index),
        .map_word          (map_word),
        .camera_x          (camera_x),
        .camera_y          (camera_y),
        .mem_wr_en         (mem_wr_en),
        .mem_wr_addr       (mem_wr_addr),
        .mem_wr_data       (mem_wr_data),
        .mem_rd_en         (mem_rd_en),
        .mem_rd_addr       (mem_rd_addr),
        .mem_rd_data       (mem_rd_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_kind       (result_kind),
        .plane_row         (plane_row),
        .plane_col         (plane_col),
        .word_top_left     (word_top_left),
        .word_top_right    (word_top_right),
        .word_bottom_left  (word_bottom_left),
        .word_bottom_right (word_bottom_right),
        .h_scroll          (h_scroll),
        .v_scroll          (v_scroll),
        .last              (last)
    );

endmodule

[rtl/core/tss_map_mem.sv]
module tss_map_mem #(
    parameter int DEPTH = 65536,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [tss_pkg::WORD_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [tss_pkg::WORD_W-1:0]  rd_data
);

    logic [tss_pkg::WORD_W-1:0] mem_reg [DEPTH];
    logic [tss_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/tss_ctrl.sv]
module tss_ctrl #(
    parameter int PLANE_COLS  = 64,
    parameter int PLANE_ROWS  = 32,
    parameter int SCREEN_COLS = 40,
    parameter int SCREEN_ROWS = 28,
    parameter int MAP_WORDS   = 65536,
    localparam int ADDR_W = $clog2(MAP_WORDS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tss_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [15:0]                   map_index,
    input  logic [tss_pkg::WORD_W-1:0]    map_word,
    input  logic [tss_pkg::PIXEL_W-1:0]   camera_x,
    input  logic [tss_pkg::PIXEL_W-1:0]   camera_y,
    output logic                          mem_wr_en,
    output logic [ADDR_W-1:0]             mem_wr_addr,
    output logic [tss_pkg::WORD_W-1:0]    mem_wr_data,
    output logic                          mem_rd_en,
    output logic [ADDR_W-1:0]             mem_rd_addr,
    input  logic [tss_pkg::WORD_W-1:0]    mem_rd_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    result_kind,
    output logic [4:0]                    plane_row,
    output logic [5:0]                    plane_col,
    output logic [tss_pkg::WORD_W-1:0]    word_top_left,
    output logic [tss_pkg::WORD_W-1:0]    word_top_right,
    output logic [tss_pkg::WORD_W-1:0]    word_bottom_left,
    output logic [tss_pkg::WORD_W-1:0]    word_bottom_right,
    output logic signed [13:0]            h_scroll,
    output logic [tss_pkg::PIXEL_W-1:0]   v_scroll,
    output logic                          last
);

    localparam int COORD_W    = tss_pkg::COORD_W;
    localparam int BASE_W     = tss_pkg::BASE_W;
    localparam int TILES_W    = tss_pkg::TILES_W;
    localparam int PIXEL_W    = tss_pkg::PIXEL_W;
    localparam int WORD_W     = tss_pkg::WORD_W;
    localparam int LIMIT_W    = TILES_W + 3;
    localparam int COL_BLOCKS = PLANE_ROWS / 2;
    localparam int ROW_BLOCKS = PLANE_COLS / 2;
    localparam int MAX_BLOCKS = (COL_BLOCKS > ROW_BLOCKS) ? COL_BLOCKS : ROW_BLOCKS;
    localparam int CNT_W      = $clog2(MAX_BLOCKS);
    localparam int RECIP_ROWS = (1 << tss_pkg::RECIP_SHIFT) / PLANE_ROWS;
    localparam int RECIP_COLS = (1 << tss_pkg::RECIP_SHIFT) / PLANE_COLS;
    localparam int RECIP_MAX  = (RECIP_ROWS > RECIP_COLS) ? RECIP_ROWS : RECIP_COLS;
    localparam int RECIP_W    = $clog2(RECIP_MAX + 1);
    localparam int PROD_W     = COORD_W + RECIP_W;
    localparam int QUOT_W     = PROD_W - tss_pkg::RECIP_SHIFT;

    tss_pkg::state_t state_reg;
    tss_pkg::state_t state_next;

    logic [TILES_W-1:0] tile_x_reg;
    logic [TILES_W-1:0] tile_y_reg;
    logic               col_pend_reg;
    logic               row_pend_reg;
    logic [1:0]         blk_kind_reg;
    logic [CNT_W-1:0]   blk_cnt_reg;
    logic [1:0]         rd_cnt_reg;
    logic               rd_pend_reg;
    logic               out_valid_reg;

    logic [PIXEL_W-1:0] x_reg;
    logic [PIXEL_W-1:0] y_reg;
    logic [COORD_W-1:0] col_start_reg;
    logic [COORD_W-1:0] row_start_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [COORD_W-1:0] prow_raw_reg;
    logic [COORD_W-1:0] pcol_raw_reg;
    logic [QUOT_W-1:0]  qr_reg;
    logic [QUOT_W-1:0]  qc_reg;
    logic [4:0]         prow_reg;
    logic [5:0]         pcol_reg;
    logic [1:0]         rd_idx_reg;
    logic [WORD_W-1:0]  word_reg [4];

    logic [1:0]         result_kind_reg;
    logic [4:0]         plane_row_reg;
    logic [5:0]         plane_col_reg;
    logic [WORD_W-1:0]  word_tl_reg;
    logic [WORD_W-1:0]  word_tr_reg;
    logic [WORD_W-1:0]  word_bl_reg;
    logic [WORD_W-1:0]  word_br_reg;
    logic signed [13:0] h_scroll_reg;
    logic [PIXEL_W-1:0] v_scroll_reg;
    logic               last_reg;

    logic               cam_xfer;
    logic               out_free;
    logic               out_load;
    logic               blk_last;
    logic [CNT_W-1:0]   blk_end;

    logic [LIMIT_W-1:0] limit_x;
    logic [LIMIT_W-1:0] limit_y;
    logic [LIMIT_W-1:0] width_px;
    logic [LIMIT_W-1:0] height_px;
    logic [PIXEL_W-1:0] x_cl;
    logic [PIXEL_W-1:0] y_cl;
    logic [TILES_W-1:0] new_tx;
    logic [TILES_W-1:0] new_ty;

    logic [COORD_W-1:0] map_row;
    logic [COORD_W-1:0] map_col;
    logic [COORD_W-1:0] prow_raw;
    logic [COORD_W-1:0] pcol_raw;
    logic [PROD_W-1:0]  row_prod;
    logic [PROD_W-1:0]  col_prod;
    logic [COORD_W-1:0] row_rem;
    logic [COORD_W-1:0] col_rem;
    logic [COORD_W-1:0] row_fix;
    logic [COORD_W-1:0] col_fix;

    // camera clamp and tile position
    always_comb
    begin
        width_px  = {cfg.map_width_tiles, 3'b000};
        height_px = {cfg.map_height_tiles, 3'b000};
        limit_x   = (width_px > LIMIT_W'(SCREEN_COLS * 8))
                    ? width_px - LIMIT_W'(SCREEN_COLS * 8) : '0;
        limit_y   = (height_px > LIMIT_W'(SCREEN_ROWS * 8))
                    ? height_px - LIMIT_W'(SCREEN_ROWS * 8) : '0;
        x_cl      = (LIMIT_W'(camera_x) > limit_x) ? PIXEL_W'(limit_x) : camera_x;
        y_cl      = (LIMIT_W'(camera_y) > limit_y) ? PIXEL_W'(limit_y) : camera_y;
        new_tx    = TILES_W'({x_cl[PIXEL_W-1:4], 1'b0});
        new_ty    = TILES_W'({y_cl[PIXEL_W-1:4], 1'b0});
    end

    // block coordinates
    always_comb
    begin
        if (blk_kind_reg == tss_pkg::KIND_COLUMN)
        begin
            map_row  = COORD_W'(tile_y_reg) + COORD_W'({blk_cnt_reg, 1'b0});
            map_col  = col_start_reg;
            prow_raw = map_row;
            pcol_raw = col_start_reg;
        end
        else
        begin
            map_row  = {row_start_reg[COORD_W-1:1], 1'b0};
            map_col  = COORD_W'(tile_x_reg) + COORD_W'({blk_cnt_reg, 1'b0});
            prow_raw = row_start_reg;
            pcol_raw = map_col;
        end
        row_prod = PROD_W'(prow_raw) * PROD_W'(RECIP_ROWS);
        col_prod = PROD_W'(pcol_raw) * PROD_W'(RECIP_COLS);
        row_rem  = prow_raw_reg - COORD_W'(qr_reg * PLANE_ROWS);
        col_rem  = pcol_raw_reg - COORD_W'(qc_reg * PLANE_COLS);
        row_fix  = (row_rem >= COORD_W'(PLANE_ROWS)) ? row_rem - COORD_W'(PLANE_ROWS) : row_rem;
        col_fix  = (col_rem >= COORD_W'(PLANE_COLS)) ? col_rem - COORD_W'(PLANE_COLS) : col_rem;
        blk_end  = (blk_kind_reg == tss_pkg::KIND_COLUMN)
                   ? CNT_W'(COL_BLOCKS - 1) : CNT_W'(ROW_BLOCKS - 1);
        blk_last = (blk_cnt_reg == blk_end);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                if (in_valid && kind == tss_pkg::ITEM_CAMERA)
                begin
                    state_next = tss_pkg::ST_SCROLL;
                end
            end
            tss_pkg::ST_SCROLL:
            begin
                if (out_free)
                begin
                    state_next = (col_pend_reg || row_pend_reg)
                                 ? tss_pkg::ST_ADDR : tss_pkg::ST_IDLE;
                end
            end
            tss_pkg::ST_ADDR:
            begin
                state_next = tss_pkg::ST_READ;
            end
            tss_pkg::ST_READ:
            begin
                if (rd_cnt_reg == 2'd3)
                begin
                    state_next = tss_pkg::ST_SETTLE;
                end
            end
            tss_pkg::ST_SETTLE:
            begin
                state_next = tss_pkg::ST_EMIT;
            end
            tss_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    if (!blk_last)
                    begin
                        state_next = tss_pkg::ST_ADDR;
                    end
                    else if (blk_kind_reg == tss_pkg::KIND_COLUMN && row_pend_reg)
                    begin
                        state_next = tss_pkg::ST_ADDR;
                    end
                    else
                    begin
                        state_next = tss_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tss_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = (state_reg == tss_pkg::ST_IDLE);
        mem_rd_en = (state_reg == tss_pkg::ST_READ);
        out_free  = !out_valid_reg || out_ready;
        out_load  = out_free && (state_reg == tss_pkg::ST_SCROLL
                                 || state_reg == tss_pkg::ST_EMIT);
        cam_xfer  = in_valid && in_ready && kind == tss_pkg::ITEM_CAMERA;
        mem_wr_en = in_valid && in_ready && kind == tss_pkg::ITEM_LOAD;
    end

    assign mem_wr_addr = ADDR_W'(map_index);
    assign mem_wr_data = map_word;
    assign mem_rd_addr = ADDR_W'(base_reg
                                 + (rd_cnt_reg[1] ? BASE_W'(cfg.map_width_tiles) : '0)
                                 + BASE_W'(rd_cnt_reg[0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tss_pkg::ST_IDLE;
            tile_x_reg    <= '0;
            tile_y_reg    <= '0;
            col_pend_reg  <= 1'b0;
            row_pend_reg  <= 1'b0;
            blk_kind_reg  <= tss_pkg::KIND_COLUMN;
            blk_cnt_reg   <= '0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= mem_rd_en;
            if (cam_xfer)
            begin
                tile_x_reg   <= new_tx;
                tile_y_reg   <= new_ty;
                col_pend_reg <= (new_tx != tile_x_reg);
                row_pend_reg <= (new_ty != tile_y_reg);
            end
            if (state_reg == tss_pkg::ST_SCROLL && out_free)
            begin
                blk_kind_reg <= col_pend_reg ? tss_pkg::KIND_COLUMN : tss_pkg::KIND_ROW;
                blk_cnt_reg  <= '0;
            end
            if (state_reg == tss_pkg::ST_EMIT && out_free)
            begin
                if (blk_last)
                begin
                    blk_kind_reg <= tss_pkg::KIND_ROW;
                    blk_cnt_reg  <= '0;
                end
                else
                begin
                    blk_cnt_reg <= blk_cnt_reg + CNT_W'(1);
                end
            end
            rd_cnt_reg <= (state_reg == tss_pkg::ST_READ) ? rd_cnt_reg + 2'd1 : 2'd0;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cam_xfer)
        begin
            x_reg         <= x_cl;
            y_reg         <= y_cl;
            col_start_reg <= (new_tx < tile_x_reg)
                             ? COORD_W'(new_tx) : COORD_W'(new_tx) + COORD_W'(SCREEN_COLS);
            row_start_reg <= (new_ty < tile_y_reg)
                             ? COORD_W'(new_ty) : COORD_W'(new_ty) + COORD_W'(SCREEN_ROWS);
        end
        if (state_reg == tss_pkg::ST_ADDR)
        begin
            base_reg     <= BASE_W'(map_row) * BASE_W'(cfg.map_width_tiles) + BASE_W'(map_col);
            prow_raw_reg <= prow_raw;
            pcol_raw_reg <= pcol_raw;
            qr_reg       <= row_prod[tss_pkg::RECIP_SHIFT +: QUOT_W];
            qc_reg       <= col_prod[tss_pkg::RECIP_SHIFT +: QUOT_W];
        end
        if (state_reg == tss_pkg::ST_READ && rd_cnt_reg == 2'd0)
        begin
            prow_reg <= row_fix[4:0];
            pcol_reg <= col_fix[5:0];
        end
        rd_idx_reg <= rd_cnt_reg;
        if (rd_pend_reg)
        begin
            word_reg[rd_idx_reg] <= mem_rd_data + cfg.tile_base_attr;
        end
        if (out_load)
        begin
            if (state_reg == tss_pkg::ST_SCROLL)
            begin
                result_kind_reg <= tss_pkg::KIND_SCROLL;
                plane_row_reg   <= '0;
                plane_col_reg   <= '0;
                word_tl_reg     <= '0;
                word_tr_reg     <= '0;
                word_bl_reg     <= '0;
                word_br_reg     <= '0;
                h_scroll_reg    <= $signed(14'd0 - {1'b0, x_reg});
                v_scroll_reg    <= y_reg;
                last_reg        <= !col_pend_reg && !row_pend_reg;
            end
            else
            begin
                result_kind_reg <= blk_kind_reg;
                plane_row_reg   <= prow_reg;
                plane_col_reg   <= pcol_reg;
                word_tl_reg     <= word_reg[0];
                word_tr_reg     <= word_reg[1];
                word_bl_reg     <= word_reg[2];
                word_br_reg     <= word_reg[3];
                h_scroll_reg    <= '0;
                v_scroll_reg    <= '0;
                last_reg        <= blk_last
                                   && (blk_kind_reg == tss_pkg::KIND_ROW || !row_pend_reg);
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign result_kind       = result_kind_reg;
    assign plane_row         = plane_row_reg;
    assign plane_col         = plane_col_reg;
    assign word_top_left     = word_tl_reg;
    assign word_top_right    = word_tr_reg;
    assign word_bottom_left  = word_bl_reg;
    assign word_bottom_right = word_br_reg;
    assign h_scroll          = h_scroll_reg;
    assign v_scroll          = v_scroll_reg;
    assign last              = last_reg;

endmodule

[rtl/core/tss_checker.sv]
module tss_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            kind,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [1:0]                      result_kind,
    input logic [4:0]                      plane_row,
    input logic [5:0]                      plane_col,
    input logic [15:0]                     word_top_left,
    input logic [15:0]                     word_top_right,
    input logic [15:0]                     word_bottom_left,
    input logic [15:0]                     word_bottom_right,
    input logic signed [13:0]              h_scroll,
    input logic [12:0]                     v_scroll,
    input logic                            last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({result_kind, plane_row, plane_col, word_top_left, word_top_right,
                        word_bottom_left, word_bottom_right, h_scroll, v_scroll, last}))
        else $error("output transfer changed while stalled");

    a_scroll_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == tss_pkg::KIND_SCROLL |->
            plane_row == '0 && plane_col == '0 && word_top_left == '0
            && word_top_right == '0 && word_bottom_left == '0 && word_bottom_right == '0
            && (h_scroll[13] || h_scroll == '0))
        else $error("scroll result carries block fields");

    a_block_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != tss_pkg::KIND_SCROLL |->
            (result_kind == tss_pkg::KIND_COLUMN || result_kind == tss_pkg::KIND_ROW)
            && h_scroll == '0 && v_scroll == '0)
        else $error("block result carries scroll fields");

    a_busy_after_camera: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == tss_pkg::ITEM_CAMERA |=> !in_ready)
        else $error("input taken during camera update");

endmodule

bind tilemap_scroll_streamer tss_checker u_tss_checker (.*);

[dv/tilemap_scroll_streamer_tb.sv]
`timescale 1ns / 1ps

module tilemap_scroll_streamer_tb;

    localparam int PLANE_COLS  = 64;
    localparam int PLANE_ROWS  = 32;
    localparam int SCREEN_COLS = 40;
    localparam int SCREEN_ROWS = 28;
    localparam int MAP_WORDS   = 65536;

    localparam int          SETTLE_CYCLES = 16;
    localparam int          PHASE_ITEMS   = 65;
    localparam int unsigned CYCLE_LIMIT   = 5_000_000;

    typedef struct {
        logic        kind;
        logic [15:0] map_index;
        logic [15:0] map_word;
        logic [12:0] camera_x;
        logic [12:0] camera_y;
    } tile_item_t;

    typedef struct {
        logic [1:0]         result_kind;
        logic [4:0]         plane_row;
        logic [5:0]         plane_col;
        logic [15:0]        word_top_left;
        logic [15:0]        word_top_right;
        logic [15:0]        word_bottom_left;
        logic [15:0]        word_bottom_right;
        logic signed [13:0] h_scroll;
        logic [12:0]        v_scroll;
        logic               last;
    } tile_result_t;

    typedef struct {
        logic [1:0]  result_kind;
        int unsigned prow;
        int unsigned pcol;
        int unsigned addr;
    } plane_block_t;

    class tile_scoreboard;
        logic [15:0]  map_mem [MAP_WORDS];
        bit           map_set [MAP_WORDS];
        logic [10:0]  width_tiles;
        logic [10:0]  height_tiles;
        logic [15:0]  base_attr;
        int unsigned  tile_x;
        int unsigned  tile_y;
        tile_result_t expected_q[$];
        int           errors;

        function new();
            width_tiles  = tss_pkg::MAP_WIDTH_RESET;
            height_tiles = tss_pkg::MAP_HEIGHT_RESET;
            base_attr    = tss_pkg::TILE_ATTR_RESET;
            tile_x       = 0;
            tile_y       = 0;
            errors       = 0;
        endfunction

        function void set_register(logic [tss_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [tss_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tss_pkg::REG_MAP_WIDTH:  width_tiles  = data[10:0];
                tss_pkg::REG_MAP_HEIGHT: height_tiles = data[10:0];
                tss_pkg::REG_TILE_ATTR:  base_attr    = data;
                default:        ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int unsigned scroll_limit(int unsigned tiles, int unsigned screen);
            return (tiles > screen) ? (tiles - screen) * 8 : 0;
        endfunction

        function int unsigned limit_x();
            return scroll_limit(width_tiles, SCREEN_COLS);
        endfunction

        function int unsigned limit_y();
            return scroll_limit(height_tiles, SCREEN_ROWS);
        endfunction

        function logic [15:0] plane_word(int unsigned a);
            logic [15:0] v;
            v = map_mem[a % MAP_WORDS];
            return v + base_attr;
        endfunction

        // List the blocks a camera request rewrites, from the current tile position.
        function void plan_camera(input logic [12:0] req_x, input logic [12:0] req_y,
                                  output int unsigned px, output int unsigned py,
                                  output int unsigned nx, output int unsigned ny,
                                  ref plane_block_t blocks[$]);
            int unsigned k, r, c, pair_col, pair_row;
            blocks.delete();
            px = (req_x > limit_x()) ? limit_x() : req_x;
            py = (req_y > limit_y()) ? limit_y() : req_y;
            nx = (px >> 3) & 32'h7FE;
            ny = (py >> 3) & 32'h7FE;
            if (nx != tile_x)
            begin
                pair_col = (nx < tile_x) ? nx : nx + SCREEN_COLS;
                for (k = 0; k < PLANE_ROWS / 2; k++)
                begin
                    r = ny + 2 * k;
                    blocks.push_back('{tss_pkg::KIND_COLUMN, r, pair_col,
                                       r * width_tiles + pair_col});
                end
            end
            if (ny != tile_y)
            begin
                pair_row = (ny < tile_y) ? ny : ny + SCREEN_ROWS;
                for (k = 0; k < PLANE_COLS / 2; k++)
                begin
                    c = nx + 2 * k;
                    blocks.push_back('{tss_pkg::KIND_ROW, pair_row, c,
                                       (pair_row & ~32'd1) * width_tiles + c});
                end
            end
        endfunction

        function void missing_words(input logic [12:0] req_x, input logic [12:0] req_y,
                                    ref int unsigned need[$]);
            plane_block_t blocks[$];
            int unsigned  px, py, nx, ny, a, j;
            bit           seen[int unsigned];
            need.delete();
            plan_camera(req_x, req_y, px, py, nx, ny, blocks);
            foreach (blocks[i])
            begin
                for (j = 0; j < 4; j++)
                begin
                    a = (blocks[i].addr + j % 2 + (j / 2) * width_tiles) % MAP_WORDS;
                    if (!map_set[a] && !seen.exists(a))
                    begin
                        seen[a] = 1'b1;
                        need.push_back(a);
                    end
                end
            end
        endfunction

        function void note_input(tile_item_t it);
            plane_block_t blocks[$];
            int unsigned  px, py, nx, ny;
            tile_result_t r;
            if (it.kind == tss_pkg::ITEM_LOAD)
            begin
                map_mem[it.map_index] = it.map_word;
                map_set[it.map_index] = 1'b1;
                return;
            end
            plan_camera(it.camera_x, it.camera_y, px, py, nx, ny, blocks);
            tile_x = nx;
            tile_y = ny;
            r = '{default: '0};
            r.result_kind = tss_pkg::KIND_SCROLL;
            r.h_scroll    = 14'(32'd0 - px);
            r.v_scroll    = 13'(py);
            r.last        = (blocks.size() == 0);
            expected_q.push_back(r);
            foreach (blocks[i])
            begin
                r = '{default: '0};
                r.result_kind       = blocks[i].result_kind;
                r.plane_row         = 5'(blocks[i].prow % PLANE_ROWS);
                r.plane_col         = 6'(blocks[i].pcol % PLANE_COLS);
                r.word_top_left     = plane_word(blocks[i].addr);
                r.word_top_right    = plane_word(blocks[i].addr + 1);
                r.word_bottom_left  = plane_word(blocks[i].addr + width_tiles);
                r.word_bottom_right = plane_word(blocks[i].addr + width_tiles + 1);
                r.last              = (i == blocks.size() - 1);
                expected_q.push_back(r);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("%0t: mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [15:0] got_v, logic [15:0] want_v);
            if (got_v !== want_v)
                report($sformatf("%s got %0h want %0h", name, got_v, want_v));
        endtask

        task check_result(tile_result_t got);
            tile_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result of kind %0d with none outstanding", got.result_kind));
                return;
            end
            want = expected_q.pop_front();
            compare_field("result_kind", got.result_kind, want.result_kind);
            compare_field("plane_row", got.plane_row, want.plane_row);
            compare_field("plane_col", got.plane_col, want.plane_col);
            compare_field("word_top_left", got.word_top_left, want.word_top_left);
            compare_field("word_top_right", got.word_top_right, want.word_top_right);
            compare_field("word_bottom_left", got.word_bottom_left, want.word_bottom_left);
            compare_field("word_bottom_right", got.word_bottom_right, want.word_bottom_right);
            compare_field("h_scroll", got.h_scroll, want.h_scroll);
            compare_field("v_scroll", got.v_scroll, want.v_scroll);
            compare_field("last", got.last, want.last);
        endtask
    endclass

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tss_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [tss_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic                            kind      = tss_pkg::ITEM_LOAD;
    logic [15:0]                     map_index = '0;
    logic [15:0]                     map_word  = '0;
    logic [12:0]                     camera_x  = '0;
    logic [12:0]                     camera_y  = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [1:0]                      result_kind;
    logic [4:0]                      plane_row;
    logic [5:0]                      plane_col;
    logic [15:0]                     word_top_left;
    logic [15:0]                     word_top_right;
    logic [15:0]                     word_bottom_left;
    logic [15:0]                     word_bottom_right;
    logic signed [13:0]              h_scroll;
    logic [12:0]                     v_scroll;
    logic                            last;

    tile_scoreboard sb;
    int             in_idle_pct  = 37;
    int             out_idle_pct = 65;
    int             walk_x       = 0;
    int             walk_y       = 0;
    int unsigned    cycle_count  = 0;

    tilemap_scroll_streamer #(
        .PLANE_COLS  (PLANE_COLS),
        .PLANE_ROWS  (PLANE_ROWS),
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .MAP_WORDS   (MAP_WORDS)
    ) u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin : result_sink
        tile_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.result_kind       = result_kind;
            got.plane_row         = plane_row;
            got.plane_col         = plane_col;
            got.word_top_left     = word_top_left;
            got.word_top_right    = word_top_right;
            got.word_bottom_left  = word_bottom_left;
            got.word_bottom_right = word_bottom_right;
            got.h_scroll          = h_scroll;
            got.v_scroll          = v_scroll;
            got.last              = last;
            sb.check_result(got);
        end
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL tilemap_scroll_streamer");
            $finish;
        end
    end

    // Hold valid across back-to-back transfers; drop it only when idling.
    task automatic send_item(input tile_item_t it);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= it.kind;
        map_index <= it.map_index;
        map_word  <= it.map_word;
        camera_x  <= it.camera_x;
        camera_y  <= it.camera_y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic send_load(input logic [15:0] idx, input logic [15:0] data);
        tile_item_t it;
        it.kind      = tss_pkg::ITEM_LOAD;
        it.map_index = idx;
        it.map_word  = data;
        it.camera_x  = 13'($urandom);
        it.camera_y  = 13'($urandom);
        send_item(it);
    endtask

    // Fill every map word the update will read before the camera transfer.
    task automatic send_camera(input logic [12:0] x, input logic [12:0] y);
        int unsigned need[$];
        tile_item_t  it;
        sb.missing_words(x, y, need);
        foreach (need[i])
            send_load(16'(need[i]), 16'($urandom));
        it.kind      = tss_pkg::ITEM_CAMERA;
        it.map_index = 16'($urandom);
        it.map_word  = 16'($urandom);
        it.camera_x  = x;
        it.camera_y  = y;
        send_item(it);
    endtask

    task automatic write_reg(input logic [tss_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [tss_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic configure(input logic [10:0] w, input logic [10:0] h, input logic [15:0] attr);
        write_reg(tss_pkg::REG_MAP_WIDTH, 16'(w));
        write_reg(tss_pkg::REG_MAP_HEIGHT, 16'(h));
        write_reg(tss_pkg::REG_TILE_ATTR, attr);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int clip_pixel(int v);
        return (v < 0) ? 0 : ((v > 8191) ? 8191 : v);
    endfunction

    task automatic random_phase(input int count);
        int sel, axis, x, y;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 30)
            begin
                send_load(16'($urandom), 16'($urandom));
                continue;
            end
            sel = $urandom_range(99);
            if (sel < 60)
            begin
                axis = $urandom_range(2);
                x = walk_x;
                y = walk_y;
                if (axis != 1)
                    x = clip_pixel(walk_x + int'($urandom_range(96)) - 48);
                if (axis != 0)
                    y = clip_pixel(walk_y + int'($urandom_range(96)) - 48);
            end
            else if (sel < 85)
            begin
                x = $urandom_range(8191);
                y = $urandom_range(8191);
            end
            else
            begin
                x = $urandom_range(1) ? 8191 : 0;
                y = $urandom_range(1) ? 8191 : 0;
            end
            send_camera(13'(x), 13'(y));
            walk_x = (x > int'(sb.limit_x())) ? int'(sb.limit_x()) : x;
            walk_y = (y > int'(sb.limit_y())) ? int'(sb.limit_y()) : y;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes equal the screen, so the camera stays pinned at the origin
        send_load(16'h0000, 16'h1234);
        send_camera(13'd8191, 13'd8191);
        send_camera(13'd0, 13'd0);
        drain();

        configure(11'd1024, 11'd1024, 16'hFFFF);
        send_load(16'hFFFF, 16'hFFFF);
        send_load(16'h0000, 16'h0000);
        send_load(16'h5555, 16'hAAAA);
        send_load(16'hAAAA, 16'h5555);
        send_camera(13'd16, 13'd0);
        send_camera(13'd0, 13'd0);
        send_camera(13'd0, 13'd16);
        send_camera(13'd0, 13'd0);
        send_camera(13'd8191, 13'd8191);
        send_camera(13'd15, 13'd15);
        send_camera(13'd31, 13'd0);
        send_camera(13'd17, 13'd15);
        drain();

        configure(11'd16, 11'd8, 16'h0001);
        send_camera(13'd8191, 13'd8191);
        send_camera(13'd100, 13'd100);

        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase / 2)
                0:
                begin
                    in_idle_pct  = 37;
                    out_idle_pct = 65;
                end
                1:
                begin
                    in_idle_pct  = 65;
                    out_idle_pct = 37;
                end
                default:
                begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            case (phase)
                0:       configure(11'd1024, 11'd28, 16'($urandom));
                2:       configure(11'd40, 11'd1024, 16'h0000);
                4:       configure(11'd1024, 11'd1024, 16'hFFFF);
                default: configure(11'($urandom_range(1024, 40)), 11'($urandom_range(1024, 28)),
                                   16'($urandom));
            endcase
            random_phase(PHASE_ITEMS);
        end
        drain();

        if (sb.errors == 0)
            $display("PASS tilemap_scroll_streamer");
        else
            $display("FAIL tilemap_scroll_streamer");
        $finish;
    end

endmodule
